[src/llba_pkg.sv]
`timescale 1ns / 1ps
// Package for the least-loaded block allocator: widths, payload structs,
// sequencer states and register indexes. No dependencies.
package llba_pkg;

    localparam int MaxNodes = 16;
    localparam int IdW      = $clog2(MaxNodes);
    localparam int DataW    = 32;
    localparam int MaskW    = 16;
    localparam int CountW   = 16;
    localparam int CfgIdxW  = 2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_NODE_PRESENT_MASK = 2'd0,
        CFG_BLOCKS_PER_FILE   = 2'd1,
        CFG_ALLOCS_PER_PICK   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_AUTO     = 1'b0,
        OP_DIRECTED = 1'b1
    } t_op;

    typedef struct packed {
        logic           op;
        logic [IdW-1:0] node_id;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [IdW-1:0]   server_id;
        logic [DataW-1:0] file_id;
        logic [DataW-1:0] block_index;
    } t_res;

    typedef struct packed {
        logic [MaskW-1:0]  node_present_mask;
        logic [DataW-1:0]  blocks_per_file;
        logic [CountW-1:0] allocs_per_pick;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [IdW-1:0]   waddr;
        logic [DataW-1:0] wfile;
        logic [DataW-1:0] wused;
        logic [IdW-1:0]   raddr;
    } t_mem_req;

    typedef struct packed {
        logic [2*DataW-1:0] a;
        logic [2*DataW-1:0] b;
    } t_cmp_in;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_ARD,
        S_AEXE
    } t_state;

endpackage

[src/llba_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module llba_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/llba_cmp.sv]
`timescale 1ns / 1ps
// Shared less-than comparator on 64-bit keys, used for the pick scan and
// the full-file check. Depends on llba_pkg.
module llba_cmp (
    input  llba_pkg::t_cmp_in i_cmp,
    output logic              o_lt
);
    import llba_pkg::*;

    assign o_lt = (i_cmp.a < i_cmp.b);
endmodule

[src/llba_seq.sv]
`timescale 1ns / 1ps
// Sequencer and datapath of the allocator: sticky node, pick scan, allocation
// and result register. Depends on llba_pkg and llba_cmp.
module llba_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  llba_pkg::t_req     i_req,
    output logic               o_valid,
    output llba_pkg::t_res     o_res,
    input  llba_pkg::t_cfg     i_cfg,
    output llba_pkg::t_mem_req o_mem,
    input  logic [31:0]        i_rfile,
    input  logic [31:0]        i_rused
);
    import llba_pkg::*;

    t_state                r_state, n_state;
    logic                  r_op, n_op;
    logic [IdW-1:0]        r_tgt, n_tgt;
    logic [IdW-1:0]        r_idx, n_idx;
    logic [IdW-1:0]        r_pidx, n_pidx;
    logic                  r_pv, n_pv;
    logic                  r_have, n_have;
    logic [IdW-1:0]        r_best, n_best;
    logic [DataW-1:0]      r_bf, n_bf;
    logic [DataW-1:0]      r_bu, n_bu;
    logic [MaxNodes-1:0]   r_vld, n_vld;
    logic [IdW-1:0]        r_sticky, n_sticky;
    logic                  r_sticky_v, n_sticky_v;
    logic [CountW-1:0]     r_cnt, n_cnt;
    logic                  r_valid, n_valid;
    t_res                  r_res, n_res;

    logic [DataW-1:0]      w_file, w_used, w_nfile;
    logic [MaxNodes-1:0]   w_present;
    logic                  w_need_pick, w_lt;
    t_cmp_in               w_cmp;

    assign w_present = i_cfg.node_present_mask[MaxNodes-1:0];
    assign w_file    = r_vld[r_pidx] ? i_rfile : DataW'(1);
    assign w_used    = r_vld[r_pidx] ? i_rused : '0;
    assign w_nfile   = (&w_file) ? w_file : w_file + DataW'(1);

    assign w_need_pick = !r_sticky_v || (r_cnt >= i_cfg.allocs_per_pick)
                         || !w_present[r_sticky];

    always_comb begin
        if (r_state == S_AEXE) begin
            w_cmp.a = {{DataW{1'b0}}, w_used};
            w_cmp.b = {{DataW{1'b0}}, i_cfg.blocks_per_file};
        end else begin
            w_cmp.a = {w_file, w_used};
            w_cmp.b = {r_bf, r_bu};
        end
    end

    llba_cmp u_cmp (
        .i_cmp (w_cmp),
        .o_lt  (w_lt)
    );

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vld      <= '0;
            r_sticky   <= '0;
            r_sticky_v <= 1'b0;
            r_cnt      <= '0;
            r_valid    <= 1'b0;
            r_pv       <= 1'b0;
            r_have     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_vld      <= n_vld;
            r_sticky   <= n_sticky;
            r_sticky_v <= n_sticky_v;
            r_cnt      <= n_cnt;
            r_valid    <= n_valid;
            r_pv       <= n_pv;
            r_have     <= n_have;
        end
        r_op   <= n_op;
        r_tgt  <= n_tgt;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_best <= n_best;
        r_bf   <= n_bf;
        r_bu   <= n_bu;
        r_res  <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_tgt      = r_tgt;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_pv       = r_pv;
        n_have     = r_have;
        n_best     = r_best;
        n_bf       = r_bf;
        n_bu       = r_bu;
        n_vld      = r_vld;
        n_sticky   = r_sticky;
        n_sticky_v = r_sticky_v;
        n_cnt      = r_cnt;
        n_valid    = 1'b0;
        n_res      = r_res;
        o_mem      = '0;
        o_mem.waddr = r_tgt;
        o_mem.raddr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_req.op;
                    n_res = '0;
                    if (i_req.op == OP_DIRECTED) begin
                        if (w_present[i_req.node_id]) begin
                            n_tgt   = i_req.node_id;
                            n_state = S_ARD;
                        end else begin
                            n_valid = 1'b1;
                        end
                    end else if (w_need_pick) begin
                        n_cnt = '0;
                        if (w_present == '0) begin
                            n_sticky_v = 1'b0;
                            n_valid    = 1'b1;
                        end else begin
                            n_idx   = '0;
                            n_pv    = 1'b0;
                            n_have  = 1'b0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_tgt   = r_sticky;
                        n_state = S_ARD;
                    end
                end
            end
            S_SCAN, S_SCAN_END: begin
                if (r_pv && (!r_have || w_lt)) begin
                    n_have = 1'b1;
                    n_best = r_pidx;
                    n_bf   = w_file;
                    n_bu   = w_used;
                end
                if (r_state == S_SCAN) begin
                    o_mem.raddr = r_idx;
                    n_pidx      = r_idx;
                    n_pv        = w_present[r_idx];
                    n_idx       = r_idx + IdW'(1);
                    if (r_idx == IdW'(MaxNodes - 1)) begin
                        n_state = S_SCAN_END;
                    end
                end else begin
                    n_pv       = 1'b0;
                    n_tgt      = n_best;
                    n_sticky   = n_best;
                    n_sticky_v = 1'b1;
                    n_state    = S_ARD;
                end
            end
            S_ARD: begin
                o_mem.raddr = r_tgt;
                n_pidx      = r_tgt;
                n_state     = S_AEXE;
            end
            S_AEXE: begin
                o_mem.we        = 1'b1;
                n_vld[r_tgt]    = 1'b1;
                n_res.ok        = 1'b1;
                n_res.server_id = r_tgt;
                if (w_lt) begin
                    o_mem.wfile       = w_file;
                    o_mem.wused       = w_used + DataW'(1);
                    n_res.file_id     = w_file;
                    n_res.block_index = w_used;
                end else begin
                    o_mem.wfile       = w_nfile;
                    o_mem.wused       = DataW'(1);
                    n_res.file_id     = w_nfile;
                    n_res.block_index = '0;
                end
                if (r_op == OP_AUTO) begin
                    n_cnt = r_cnt + CountW'(1);
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted request produced neither work nor a result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.ok) |->
            (o_res.server_id == '0 && o_res.file_id == '0 && o_res.block_index == '0))
        else $error("failed result carries non-zero fields");

    a_file_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.ok) |-> (o_res.file_id != '0))
        else $error("allocated block reports file zero");

    a_scan_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SCAN_END) |-> (r_op == OP_AUTO))
        else $error("pick scan running for a directed request");
endmodule

[src/least_loaded_block_allocator.sv]
`timescale 1ns / 1ps
// Least-loaded block allocator: top level with configuration registers and
// per-node file/used tables. Depends on llba_pkg, llba_ram and llba_seq.
//
// Usage:
//   Requests: drive i_req (op, node_id) with start high; the request is taken
//   at a rising edge where start is high and busy is low.
//   Results: o_res is shown for exactly one cycle with o_valid high; the
//   receiver cannot stall and must take it in that cycle.
//   Configuration: i_cfg_we, i_cfg_idx, i_cfg_wdata write register i_cfg_idx
//   (0 present mask, 1 blocks per file, 2 allocations per pick) at once;
//   write only while busy is low and no result is pending.
//   A failed request shows its result in the cycle after the transfer.
//   A sticky or directed allocation shows it after the table read, the
//   update and the result register.
//   A re-pick scans all 16 node entries through one comparator against the
//   registered table read, one entry a cycle, then allocates through the
//   table read, update and result register.
//   Busy drops in the cycle the result is shown, so the next request can
//   be taken then; no new request is taken while busy is high.
//   Reset: synchronous, active low; the node tables read as file 1, used 0
//   through per-entry valid bits, so no clearing pass is needed.
module least_loaded_block_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  llba_pkg::t_req                   i_req,
    output logic                             o_valid,
    output llba_pkg::t_res                   o_res,
    input  logic                             i_cfg_we,
    input  logic [llba_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [llba_pkg::DataW-1:0]       i_cfg_wdata
);
    import llba_pkg::*;

    t_cfg             r_cfg;
    t_mem_req         w_mem;
    logic [DataW-1:0] w_rfile, w_rused;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_present_mask <= MaskW'(1);
            r_cfg.blocks_per_file   <= DataW'(65536);
            r_cfg.allocs_per_pick   <= CountW'(1000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_PRESENT_MASK: r_cfg.node_present_mask <= i_cfg_wdata[MaskW-1:0];
                CFG_BLOCKS_PER_FILE:   r_cfg.blocks_per_file   <= i_cfg_wdata;
                CFG_ALLOCS_PER_PICK:   r_cfg.allocs_per_pick   <= i_cfg_wdata[CountW-1:0];
                default: ;
            endcase
        end
    end

    llba_ram #(.Width(DataW), .Depth(MaxNodes)) u_file_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wfile),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rfile)
    );

    llba_ram #(.Width(DataW), .Depth(MaxNodes)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wused),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rused)
    );

    llba_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res),
        .i_cfg   (r_cfg),
        .o_mem   (w_mem),
        .i_rfile (w_rfile),
        .i_rused (w_rused)
    );
endmodule
